// ----- rtl/stq_pkg.sv -----
// Shared types and constants for the sorted timer queue.
package stq_pkg;

	localparam int ID_W   = 4;
	localparam int TIME_W = 32;
	localparam int CMD_W  = 2;

	// command codes; code 3 is unused and ignored
	localparam logic [CMD_W-1:0] CMD_ARM     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DISARM  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SERVICE = 2'd2;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [TIME_W-1:0] sum;
		logic              later;	// sub only: a - b, read signed, above zero
	} alu_res_t;

	// one queue position: slot id and its expiry
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] exp;
	} q_entry_t;

endpackage

// ----- rtl/sorted_timer_queue_core.sv -----
// Top level of the sorted timer queue: sequencer, queue and period RAMs, shared ALU.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-------------------------------
//  command | command timer_id interval repeat_req now          | start high, busy low at edge
//  result  | fired_id                                         | fired strobe, one cycle, no stall
//
// Passes per beat: a pass walks the queue RAM one position per cycle through its single
//   read port. An arm of an idle slot makes one insert pass, an arm of a queued slot a
//   remove pass and then an insert pass, a disarm of a queued slot one remove pass; any
//   other disarm, an empty service, a service without expiry and code 3 make no pass. A
//   service with pop makes a remove pass, plus an insert pass when a periodic slot goes
//   back in.
// Reset clears the sequencer, the fill count and the queued flags; RAM contents are
//   left as they are, only queued positions and armed slots are ever read.
// busy stays high for the whole command; the result side cannot stall, fired_id is
//   valid only in the cycle fired is high.
module sorted_timer_queue_core #(
	parameter int NUM_TIMERS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [stq_pkg::CMD_W-1:0]  command,
	input  logic [stq_pkg::ID_W-1:0]   timer_id,
	input  logic [stq_pkg::TIME_W-1:0] interval,
	input  logic                       repeat_req,
	input  logic [stq_pkg::TIME_W-1:0] now,
	output logic                       fired,
	output logic [stq_pkg::ID_W-1:0]   fired_id
);
	import stq_pkg::*;

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNT_W = $clog2(NUM_TIMERS + 1);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DECODE   = 7'b0000010,
		S_HEAD_CHK = 7'b0000100,
		S_POP      = 7'b0001000,
		S_RM       = 7'b0010000,
		S_ADD      = 7'b0100000,
		S_INS      = 7'b1000000
	} state_t;

	function automatic logic [IDX_W-1:0] to_idx(input logic [ID_W-1:0] id);
		logic [IDX_W+ID_W-1:0] ext;
		begin
			ext = (IDX_W+ID_W)'(id);
			return ext[IDX_W-1:0];
		end
	endfunction

	// control state
	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_TIMERS-1:0] queued_q;
	logic [CNT_W-1:0]      rd_pos_q;
	logic                  dv_q;
	logic                  found_q;
	logic                  fired_q;

	// payload
	logic [CMD_W-1:0]      cmd_q;
	logic [ID_W-1:0]       tid_q;
	logic [TIME_W-1:0]     interval_q;
	logic                  rep_q;
	logic [TIME_W-1:0]     now_q;
	logic [TIME_W-1:0]     when_q;
	logic [TIME_W-1:0]     head_exp_q;
	logic [TIME_W-1:0]     per_q;
	logic [CNT_W-1:0]      dpos_q;
	q_entry_t              carry_q;
	logic [ID_W-1:0]       fired_id_q;

	// queue RAM, indexed by position
	logic                  ord_we;
	logic [IDX_W-1:0]      ord_waddr;
	q_entry_t              ord_wdata;
	logic [IDX_W-1:0]      ord_raddr;
	logic [$bits(q_entry_t)-1:0] ord_rdata_raw;
	q_entry_t              ord_rdata;

	// period RAM, indexed by slot
	logic                  per_we;
	logic [TIME_W-1:0]     per_wdata;
	logic [TIME_W-1:0]     per_rdata;

	logic [TIME_W-1:0]     alu_a;
	logic [TIME_W-1:0]     alu_b;
	alu_op_t               alu_op;
	alu_res_t              alu_res;

	logic [IDX_W-1:0]      tidx;
	logic                  id_ok;
	logic                  pass;
	logic                  rd_issue;
	logic                  pass_end;
	logic [CNT_W-1:0]      dpos_m1;
	q_entry_t              new_ent;
	logic                  not_full;

	assign ord_rdata = q_entry_t'(ord_rdata_raw);
	assign tidx      = to_idx(tid_q);
	assign id_ok     = 32'(tid_q) < 32'(NUM_TIMERS);
	assign pass      = (state_q == S_RM) || (state_q == S_INS);
	assign rd_issue  = pass && (rd_pos_q < cnt_q);
	assign pass_end  = pass && !dv_q && (rd_pos_q == cnt_q);
	assign dpos_m1   = dpos_q - CNT_W'(1);
	assign new_ent   = '{id: tid_q, exp: when_q};
	assign not_full  = cnt_q < CNT_W'(NUM_TIMERS);

	assign busy     = (state_q != S_IDLE);
	assign fired    = fired_q;
	assign fired_id = fired_id_q;

	// outside a pass the queue RAM sits on the head position
	assign ord_raddr = pass ? rd_pos_q[IDX_W-1:0] : '0;

	// queue RAM writes: shift left behind the removed slot, carry right behind the new one
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = dpos_q[IDX_W-1:0];
		ord_wdata = carry_q;
		if (state_q == S_RM && dv_q && found_q) begin
			ord_we    = 1'b1;
			ord_waddr = dpos_m1[IDX_W-1:0];
			ord_wdata = ord_rdata;
		end
		if (state_q == S_INS && dv_q) begin
			if (found_q) begin
				ord_we = 1'b1;
			end else if (alu_res.later) begin
				ord_we    = 1'b1;
				ord_wdata = new_ent;
			end
		end
		if (state_q == S_INS && pass_end) begin
			ord_we    = 1'b1;
			ord_waddr = cnt_q[IDX_W-1:0];
			ord_wdata = found_q ? carry_q : new_ent;
		end
	end

	assign per_we    = (state_q == S_ADD) && (cmd_q == CMD_ARM);
	assign per_wdata = rep_q ? interval_q : '0;

	// shared ALU operand select
	always_comb begin
		alu_a  = ord_rdata.exp;
		alu_b  = when_q;
		alu_op = ALU_SUB;
		unique case (state_q)
			S_HEAD_CHK: begin
				alu_b = now_q;
			end
			S_ADD: begin
				alu_op = ALU_ADD;
				if (cmd_q == CMD_ARM) begin
					alu_a = now_q;
					alu_b = interval_q;
				end else begin
					alu_a = head_exp_q;
					alu_b = per_q;
				end
			end
			default: begin
			end
		endcase
	end

	stq_ram #(
		.WIDTH ($bits(q_entry_t)),
		.DEPTH (NUM_TIMERS)
	) u_order_ram (
		.clk   (clk),
		.we    (ord_we),
		.waddr (ord_waddr),
		.wdata (ord_wdata),
		.raddr (ord_raddr),
		.rdata (ord_rdata_raw)
	);

	// read address follows the head id; the registered read data is taken in S_POP
	stq_ram #(
		.WIDTH (TIME_W),
		.DEPTH (NUM_TIMERS)
	) u_period_ram (
		.clk   (clk),
		.we    (per_we),
		.waddr (tidx),
		.wdata (per_wdata),
		.raddr (to_idx(ord_rdata.id)),
		.rdata (per_rdata)
	);

	stq_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.op  (alu_op),
		.res (alu_res)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			queued_q <= '0;
			rd_pos_q <= '0;
			dv_q     <= 1'b0;
			found_q  <= 1'b0;
			fired_q  <= 1'b0;
		end else begin
			fired_q <= 1'b0;

			// pass walker: one read issued per cycle, data handled the next
			if (pass) begin
				if (rd_issue) begin
					rd_pos_q <= rd_pos_q + CNT_W'(1);
				end
				dv_q <= rd_issue;
				if (dv_q) begin
					if (state_q == S_RM && ord_rdata.id == tid_q) begin
						found_q <= 1'b1;
					end
					if (state_q == S_INS && !found_q && alu_res.later) begin
						found_q <= 1'b1;
					end
				end
			end else begin
				rd_pos_q <= '0;
				dv_q     <= 1'b0;
				found_q  <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (cmd_q == CMD_ARM) begin
						if (!id_ok) begin
							state_q <= S_IDLE;
						end else if (queued_q[tidx]) begin
							state_q <= S_RM;
						end else begin
							state_q <= S_ADD;
						end
					end else if (cmd_q == CMD_DISARM) begin
						state_q <= (id_ok && queued_q[tidx]) ? S_RM : S_IDLE;
					end else if (cmd_q == CMD_SERVICE) begin
						state_q <= (cnt_q != '0) ? S_HEAD_CHK : S_IDLE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_HEAD_CHK: begin
					state_q <= alu_res.later ? S_IDLE : S_POP;
				end
				S_POP: begin
					fired_q <= 1'b1;
					state_q <= S_RM;
				end
				S_RM: begin
					if (pass_end) begin
						if (found_q) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
						queued_q[tidx] <= 1'b0;
						if (cmd_q == CMD_ARM) begin
							state_q <= S_ADD;
						end else if (cmd_q == CMD_SERVICE && per_q != '0) begin
							state_q <= S_ADD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ADD: begin
					state_q <= not_full ? S_INS : S_IDLE;
				end
				S_INS: begin
					if (pass_end) begin
						cnt_q          <= cnt_q + CNT_W'(1);
						queued_q[tidx] <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q      <= command;
			tid_q      <= timer_id;
			interval_q <= interval;
			rep_q      <= repeat_req;
			now_q      <= now;
		end
		if (state_q == S_HEAD_CHK) begin
			tid_q      <= ord_rdata.id;
			head_exp_q <= ord_rdata.exp;
		end
		if (state_q == S_POP) begin
			per_q      <= per_rdata;
			fired_id_q <= tid_q;
		end
		if (state_q == S_ADD) begin
			when_q <= alu_res.sum;
		end
		if (rd_issue) begin
			dpos_q <= rd_pos_q;
		end
		if (state_q == S_INS && dv_q && (found_q || alu_res.later)) begin
			carry_q <= ord_rdata;
		end
	end

	// a result only comes out while a command is in progress
	a_fired_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fired |-> busy)
		else $error("fired strobe outside a command");

	// between commands the fill count matches the queued flags
	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> ($countones(queued_q) == int'(cnt_q)))
		else $error("queue count and queued flags disagree");

	// an accepted beat always takes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted beat did not raise busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_TIMERS))
		else $error("queue count beyond capacity");

endmodule

// ----- rtl/stq_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module stq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/stq_alu.sv -----
// Shared 32-bit add/subtract unit with wrap-around "later than" flag.
module stq_alu (
	input  logic [stq_pkg::TIME_W-1:0] a,
	input  logic [stq_pkg::TIME_W-1:0] b,
	input  stq_pkg::alu_op_t           op,
	output stq_pkg::alu_res_t          res
);
	import stq_pkg::*;

	logic [TIME_W-1:0] b_x;
	logic [TIME_W-1:0] sum;

	always_comb begin
		b_x = (op == ALU_SUB) ? ~b : b;
		sum = a + b_x + TIME_W'(op == ALU_SUB);
		res.sum   = sum;
		res.later = (sum != '0) && !sum[TIME_W-1];
	end

endmodule

// ----- test/tb_sorted_timer_queue_core.sv -----
// Self-checking testbench for the sorted timer queue core: directed and random command beats.
module tb_sorted_timer_queue_core;
	import stq_pkg::*;

	localparam int SLOTS = 16;
	// code 3 has no meaning to the block and must be dropped without a result
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 1450;
	// quiet cycles after the last beat; well above the longest pass over a full queue
	localparam int SETTLE_CYCLES = 100;
	// bound on waiting for outstanding expiries once the block has gone idle
	localparam int DRAIN_LIMIT = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [CMD_W-1:0]  command = CMD_SERVICE;
	logic [ID_W-1:0]   timer_id = '0;
	logic [TIME_W-1:0] interval = '0;
	logic              repeat_req = 1'b0;
	logic [TIME_W-1:0] now = '0;
	logic              fired;
	logic [ID_W-1:0]   fired_id;

	sorted_timer_queue_core #(
		.NUM_TIMERS(SLOTS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.timer_id  (timer_id),
		.interval  (interval),
		.repeat_req(repeat_req),
		.now       (now),
		.fired     (fired),
		.fired_id  (fired_id)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Shadow of the timer queue. Updated at the edge that accepts a beat,
	// so the expected firing order is always ahead of the block.
	// ---------------------------------------------------------------------
	logic [TIME_W-1:0] slot_expiry [SLOTS];
	logic [TIME_W-1:0] slot_period [SLOTS];	// zero means one-shot
	logic              slot_queued [SLOTS];
	logic [ID_W-1:0]   expiry_order [$];	// queued ids, earliest expiry first
	logic [ID_W-1:0]   fired_due [$];		// ids the block still owes us

	logic [TIME_W-1:0] tick;				// our notion of the free-running count
	bit                no_gaps = 1'b0;		// back-to-back stretches
	int                errors = 0;
	int                beats_sent = 0;
	int                arms_sent = 0;
	int                disarms_sent = 0;
	int                services_sent = 0;
	int                fires_seen = 0;

	// a strictly later than b, judged on the wrapped signed difference
	function automatic logic is_later(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[TIME_W-1];
	endfunction

	// insert behind every entry that is not later, so equal expiries keep arrival order
	function automatic void insert_by_expiry(logic [ID_W-1:0] id, logic [TIME_W-1:0] when);
		int pos;
		pos = 0;
		if (expiry_order.size() >= SLOTS)
			return;
		while (pos < expiry_order.size() && !is_later(slot_expiry[expiry_order[pos]], when))
			pos++;
		expiry_order.insert(pos, id);
		slot_expiry[id] = when;
		slot_queued[id] = 1'b1;
	endfunction

	// take one slot out wherever it sits; a slot not queued is left alone
	function automatic void unlink_slot(logic [ID_W-1:0] id);
		if (!slot_queued[id])
			return;
		for (int i = 0; i < expiry_order.size(); i++) begin
			if (expiry_order[i] == id) begin
				expiry_order.delete(i);
				break;
			end
		end
		slot_queued[id] = 1'b0;
	endfunction

	function automatic void advance_timer_queue(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
		logic [TIME_W-1:0] ival, logic rep, logic [TIME_W-1:0] t);
		logic [ID_W-1:0] head;
		case (cmd)
			CMD_ARM: begin
				unlink_slot(id);
				slot_period[id] = rep ? ival : '0;
				insert_by_expiry(id, t + ival);
			end
			CMD_DISARM: begin
				unlink_slot(id);
			end
			CMD_SERVICE: begin
				// head has expired once its expiry is no longer later than now
				if (expiry_order.size() != 0 && !is_later(slot_expiry[expiry_order[0]], t)) begin
					head = expiry_order.pop_front();
					slot_queued[head] = 1'b0;
					if (slot_period[head] != '0)
						insert_by_expiry(head, slot_expiry[head] + slot_period[head]);
					fired_due.push_back(head);
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Command side: inputs move on the falling edge, the beat is taken at the
	// first rising edge with busy low. start is left high after a beat so a
	// zero gap gives true back-to-back traffic.
	// ---------------------------------------------------------------------
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
		input logic [TIME_W-1:0] ival, input logic rep, input logic [TIME_W-1:0] t);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		repeat (gap) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		command    <= cmd;
		timer_id   <= id;
		interval   <= ival;
		repeat_req <= rep;
		now        <= t;
		do
			@(posedge clk);
		while (busy);
		advance_timer_queue(cmd, id, ival, rep, t);
		beats_sent++;
		case (cmd)
			CMD_ARM:     arms_sent++;
			CMD_DISARM:  disarms_sent++;
			CMD_SERVICE: services_sent++;
			default: ;
		endcase
	endtask

	// stop sending and let the block finish everything it owes
	task automatic wait_quiet();
		@(negedge clk);
		start <= 1'b0;
		do
			@(posedge clk);
		while (busy);
		for (int c = 0; c < DRAIN_LIMIT && fired_due.size() != 0; c++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Result side: fired is a one-cycle strobe that cannot be held off, so
	// every strobe seen at a rising edge must match the oldest expiry owed.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_fired
		logic [ID_W-1:0] due_id;
		if (arst_n && fired === 1'b1) begin
			fires_seen++;
			if (fired_due.size() == 0) begin
				$error("fired_id: expected nothing, got %0d", fired_id);
				errors++;
			end else begin
				due_id = fired_due.pop_front();
				if (fired_id !== due_id) begin
					$error("fired_id: expected %0d, got %0d", due_id, fired_id);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Directed tests
	// ---------------------------------------------------------------------

	// empty-queue service, the unused code, a stray disarm, and a zero
	// interval with repeat that must behave as a one-shot
	task automatic test_empty_and_ignored();
		tick = $urandom();
		send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, tick);
		send_beat(CMD_UNUSED, 4'd5, $urandom(), 1'b1, tick);
		send_beat(CMD_DISARM, 4'd9, '0, 1'b0, tick);
		send_beat(CMD_ARM, 4'd0, '0, 1'b1, tick);
		send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, tick);
		send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, tick);
	endtask

	// equal expiries keep arrival order; a periodic slot lands behind them
	task automatic test_ordering();
		tick = $urandom();
		send_beat(CMD_ARM, 4'd15, 32'd10, 1'b0, tick);
		send_beat(CMD_ARM, 4'd3, 32'd10, 1'b0, tick);
		send_beat(CMD_ARM, 4'd7, 32'd5, 1'b1, tick);
		send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, tick + 32'd4);	// one tick short
		send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, tick + 32'd5);
		repeat (3) send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, tick + 32'd10);
	endtask

	// disarm of the head must leave the rest; re-arm of a queued slot moves it
	task automatic test_disarm_and_rearm();
		tick = $urandom();
		send_beat(CMD_ARM, 4'd1, 32'd100, 1'b0, tick);
		send_beat(CMD_ARM, 4'd2, 32'd200, 1'b0, tick);
		send_beat(CMD_DISARM, 4'd1, '0, 1'b0, tick);
		send_beat(CMD_ARM, 4'd2, 32'd20, 1'b1, tick);
		send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, tick + 32'd200);
		send_beat(CMD_DISARM, 4'd2, '0, 1'b0, tick);
	endtask

	// wrap of the tick count and intervals at the signed boundary
	task automatic test_extremes();
		tick = 32'hFFFF_FFF0;
		send_beat(CMD_ARM, 4'd8, 32'hFFFF_FFFF, 1'b1, tick);	// already in the past
		send_beat(CMD_ARM, 4'd6, 32'h7FFF_FFFF, 1'b0, tick);	// furthest future
		send_beat(CMD_ARM, 4'd5, 32'h8000_0000, 1'b0, tick);	// reads as past
		repeat (3) send_beat(CMD_SERVICE, 4'd0, '0, 1'b0, 32'h0000_0005);
		send_beat(CMD_DISARM, 4'd8, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_beat(CMD_DISARM, 4'd6, '0, 1'b0, '0);
	endtask

	// ---------------------------------------------------------------------
	// Random traffic: mostly arms and services against a slowly advancing
	// tick, so periodic slots keep cycling through the queue; now and then a
	// large jump or a full-width interval stirs up the wrap-around ordering.
	// ---------------------------------------------------------------------
	task automatic test_random_traffic();
		int pick;
		int sel;
		logic [TIME_W-1:0] ival;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 48 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_BEATS / 2)
				wait_quiet();		// hold off until the queue has paid out
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				sel = $urandom_range(0, 19);
				case (sel)
					0: ival = $urandom();
					1: begin
						case ($urandom_range(0, 3))
							0: ival = '0;
							1: ival = 32'hFFFF_FFFF;
							2: ival = 32'h7FFF_FFFF;
							default: ival = 32'h8000_0000;
						endcase
					end
					default: ival = $urandom_range(0, 120);
				endcase
				tick += $urandom_range(0, 3);
				send_beat(CMD_ARM, ID_W'($urandom_range(0, SLOTS - 1)), ival,
					1'($urandom_range(0, 1)), tick);
			end else if (pick < 52) begin
				send_beat(CMD_DISARM, ID_W'($urandom_range(0, SLOTS - 1)), $urandom(),
					1'($urandom_range(0, 1)), $urandom());
			end else if (pick < 97) begin
				if ($urandom_range(0, 63) == 0)
					tick += $urandom();
				else
					tick += $urandom_range(0, 30);
				send_beat(CMD_SERVICE, ID_W'($urandom_range(0, SLOTS - 1)), $urandom(),
					1'($urandom_range(0, 1)), tick);
			end else begin
				send_beat(CMD_UNUSED, ID_W'($urandom_range(0, SLOTS - 1)), $urandom(),
					1'($urandom_range(0, 1)), $urandom());
			end
		end
	endtask

	initial begin
		foreach (slot_queued[i])
			slot_queued[i] = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_and_ignored();
		test_ordering();
		test_disarm_and_rearm();
		test_extremes();
		wait_quiet();
		test_random_traffic();
		wait_quiet();

		if (fired_due.size() != 0) begin
			$error("fired_id: %0d expiries never reported, next expected %0d",
				fired_due.size(), fired_due[0]);
			errors++;
		end
		$display("Sent %0d beats (%0d arm, %0d disarm, %0d service), %0d expiries fired.",
			beats_sent, arms_sent, disarms_sent, services_sent, fires_seen);
		$display("Covered equal expiries, periodic re-queue, head disarm and tick wrap-around.");
		if (errors == 0)
			$display("** sorted_timer_queue_core: PASSED **");
		else
			$display("** sorted_timer_queue_core: FAILED **");
		$finish;
	end

	// watchdog: several times the slowest legal run
	initial begin
		#5_000_000;
		$display("** sorted_timer_queue_core: FAILED **");
		$finish;
	end

endmodule

// ----- sorted_timer_queue_core.f -----
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/stq_alu.sv
rtl/sorted_timer_queue_core.sv
test/tb_sorted_timer_queue_core.sv
